FILE: src/bmlq_pkg.sv
// bmlq_pkg: shared constants and codes for the banked message log queue
// no dependencies; imported by bmlq_sram, banked_message_log_queue, bmlq_checker and banked_message_log_queue_tb
package bmlq_pkg;

    // default geometry
    localparam int DEF_NUM_BANKS    = 4;
    localparam int DEF_BANK_BYTES   = 4096;
    localparam int DEF_BANK_ENTRIES = 64;

    // fixed field widths of the ports
    localparam int KIND_W   = 2;
    localparam int LEN_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int BANK_W   = 2;
    localparam int OFFSET_W = 12;
    localparam int COUNT_W  = 12;
    localparam int STATUS_W = 2;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_START = 2'd0,
        K_PUSH_BYTE  = 2'd1,
        K_POP        = 2'd2,
        K_READ_BYTE  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED    = 2'd0,
        ST_POPPED    = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_READ_DATA = 2'd3
    } t_status;

endpackage

FILE: src/bmlq_sram.sv
// bmlq_sram: simple dual-port synchronous ram, one write and one registered read port
// depends on bmlq_pkg for default sizes
module bmlq_sram import bmlq_pkg::*; #(
    parameter int WIDTH = BYTE_W,
    parameter int DEPTH = DEF_NUM_BANKS * DEF_BANK_BYTES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/banked_message_log_queue.sv
// push_start and push_byte never make the block busy: a new item is taken every cycle and the
// push_start result strobes the cycle after acceptance. pop checks the table, reads the
// entry, then strobes; an empty queue skips the read, a step to the next bank adds a check.
// read_byte strobes after the registered byte store read. results cannot be stalled.
// synchronous active-low reset clears the bank pointers, per-bank counters and open
// message state; entry table and byte store are not cleared
module banked_message_log_queue import bmlq_pkg::*; #(
    parameter int NUM_BANKS    = DEF_NUM_BANKS,
    parameter int BANK_BYTES   = DEF_BANK_BYTES,
    parameter int BANK_ENTRIES = DEF_BANK_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic                i_msg_type,
    input  logic [LEN_W-1:0]    i_msg_len,
    input  logic [BYTE_W-1:0]   i_data_byte,
    input  logic [BANK_W-1:0]   i_read_bank,
    input  logic [OFFSET_W-1:0] i_read_offset,
    output logic                o_strobe,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_stored_count,
    output logic                o_type_out,
    output logic [BANK_W-1:0]   o_bank_out,
    output logic [OFFSET_W-1:0] o_offset_out,
    output logic [BYTE_W-1:0]   o_data_out,
    output logic                o_overrun
);

    localparam int BW       = $clog2(NUM_BANKS);
    localparam int OW       = $clog2(BANK_BYTES);
    localparam int CW       = $clog2(BANK_BYTES + 1);
    localparam int EW       = $clog2(BANK_ENTRIES);
    localparam int KW       = $clog2(BANK_ENTRIES + 1);
    localparam int BS_DEPTH = NUM_BANKS * BANK_BYTES;
    localparam int BS_AW    = $clog2(BS_DEPTH);
    localparam int ET_DEPTH = NUM_BANKS * BANK_ENTRIES;
    localparam int ET_AW    = $clog2(ET_DEPTH);
    localparam int ET_W     = OW + 1;

    localparam logic [BW-1:0] LAST_BANK = BW'(NUM_BANKS - 1);
    localparam logic [OW-1:0] MAX_COUNT = OW'(BANK_BYTES - 1);
    localparam logic [KW-1:0] ENTRY_LIM = KW'(BANK_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_CHK,
        S_POP_OUT,
        S_READ
    } t_state;

    function automatic logic [BW-1:0] f_next(input logic [BW-1:0] b);
        return (b == LAST_BANK) ? '0 : b + 1'b1;
    endfunction

    function automatic logic [BS_AW-1:0] f_bs_addr(input logic [BW-1:0] b,
                                                   input logic [OW-1:0] off);
        return BS_AW'(b) * BS_AW'(BANK_BYTES) + BS_AW'(off);
    endfunction

    function automatic logic [ET_AW-1:0] f_et_addr(input logic [BW-1:0] b,
                                                   input logic [EW-1:0] idx);
        return ET_AW'(b) * ET_AW'(BANK_ENTRIES) + ET_AW'(idx);
    endfunction

    t_state r_state;

    logic [BW-1:0] r_wb;
    logic [BW-1:0] r_rb;
    logic [15:0]   r_taken;
    logic [OW-1:0] r_open_count;
    logic [OW-1:0] r_open_start;
    logic          r_open_trunc;

    logic [BW-1:0] r_pop_bank;
    logic [KW-1:0] r_pop_read;
    logic [CW-1:0] r_pop_rcur;
    logic          r_rd_ok;

    logic                r_strobe;
    logic [STATUS_W-1:0] r_status;
    logic [COUNT_W-1:0]  r_stored_count;
    logic                r_type_out;
    logic [BANK_W-1:0]   r_bank_out;
    logic [OFFSET_W-1:0] r_offset_out;
    logic [BYTE_W-1:0]   r_data_out;
    logic                r_overrun;

    // per-bank bookkeeping, one read address and one write address per cycle
    logic [KW-1:0] r_bk_count [NUM_BANKS];
    logic [KW-1:0] r_bk_read  [NUM_BANKS];
    logic [CW-1:0] r_bk_wcur  [NUM_BANKS];
    logic [CW-1:0] r_bk_rcur  [NUM_BANKS];

    logic          accept;
    logic [BW-1:0] rd_addr;
    logic [KW-1:0] rc_count;
    logic [KW-1:0] rc_read;
    logic [CW-1:0] rc_wcur;
    logic [CW-1:0] rc_rcur;

    logic          ps_new;
    logic [BW-1:0] ps_nwb;
    logic [BW-1:0] ps_tb;
    logic          ps_ovr;
    logic          ps_trunc;
    logic [OW-1:0] ps_cnt;
    logic [KW-1:0] ps_c0;
    logic [OW-1:0] ps_s0;

    logic pp_adv;
    logic pp_empty;

    logic          pb_take;
    logic          pb_last;
    logic [OW-1:0] pb_off;

    logic rb_ok;

    logic          bw_we_w;
    logic          bw_we_r;
    logic [BW-1:0] bw_addr;
    logic [KW-1:0] bw_count;
    logic [CW-1:0] bw_wcur;
    logic [KW-1:0] bw_read;
    logic [CW-1:0] bw_rcur;

    logic              bs_we;
    logic [BS_AW-1:0]  bs_waddr;
    logic [BYTE_W-1:0] bs_wdata;
    logic              bs_re;
    logic [BS_AW-1:0]  bs_raddr;
    logic [BYTE_W-1:0] bs_rdata;

    logic             et_we;
    logic [ET_AW-1:0] et_waddr;
    logic [ET_W-1:0]  et_wdata;
    logic             et_re;
    logic [ET_AW-1:0] et_raddr;
    logic [ET_W-1:0]  et_rdata;
    logic [OW-1:0]    et_cnt;
    logic             et_type;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign rd_addr  = (r_state == S_IDLE && i_kind == K_PUSH_START) ? r_wb : r_rb;
    assign rc_count = r_bk_count[rd_addr];
    assign rc_read  = r_bk_read[rd_addr];
    assign rc_wcur  = r_bk_wcur[rd_addr];
    assign rc_rcur  = r_bk_rcur[rd_addr];

    // push_start: open the next bank when the table is full or the message won't fit
    assign ps_new   = (rc_count >= ENTRY_LIM) ||
                      (32'(rc_wcur) + 32'(i_msg_len) + 32'd1 > 32'(BANK_BYTES));
    assign ps_nwb   = f_next(r_wb);
    assign ps_tb    = ps_new ? ps_nwb : r_wb;
    assign ps_ovr   = ps_new && (r_rb == ps_nwb);
    assign ps_trunc = 32'(i_msg_len) > 32'(BANK_BYTES - 1);
    assign ps_cnt   = ps_trunc ? MAX_COUNT : OW'(i_msg_len);
    assign ps_c0    = ps_new ? '0 : rc_count;
    // a cursor that stays in the bank is always below the bank size
    assign ps_s0    = ps_new ? '0 : OW'(rc_wcur);

    assign pp_adv   = (r_rb != r_wb) && ((rc_read >= ENTRY_LIM) || (rc_read == rc_count));
    assign pp_empty = (rc_read >= rc_count) || (rc_read >= ENTRY_LIM);

    assign pb_take = r_taken < 16'(r_open_count);
    assign pb_last = r_open_trunc && (r_taken == 16'(r_open_count) - 16'd1);
    assign pb_off  = r_open_start + OW'(r_taken);

    assign rb_ok = (32'(i_read_bank) < NUM_BANKS) && (32'(i_read_offset) < BANK_BYTES);

    assign et_cnt  = et_rdata[OW-1:0];
    assign et_type = et_rdata[OW];

    always_comb begin
        bw_we_w  = 1'b0;
        bw_we_r  = 1'b0;
        bw_addr  = r_pop_bank;
        bw_count = ps_c0 + 1'b1;
        bw_wcur  = CW'(ps_s0) + CW'(ps_cnt) + 1'b1;
        bw_read  = r_pop_read + 1'b1;
        bw_rcur  = r_pop_rcur + CW'(et_cnt) + 1'b1;
        bs_we    = 1'b0;
        bs_waddr = f_bs_addr(ps_tb, ps_s0 + ps_cnt);
        bs_wdata = '0;
        bs_re    = 1'b0;
        bs_raddr = f_bs_addr(BW'(i_read_bank), OW'(i_read_offset));
        et_we    = 1'b0;
        et_waddr = f_et_addr(ps_tb, ps_c0[EW-1:0]);
        et_wdata = {i_msg_type, ps_cnt};
        et_re    = 1'b0;
        et_raddr = f_et_addr(r_rb, rc_read[EW-1:0]);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_kind'(i_kind))
                        K_PUSH_START: begin
                            bw_addr = ps_tb;
                            bw_we_w = 1'b1;
                            bw_we_r = ps_new;
                            bw_read = '0;
                            bw_rcur = '0;
                            et_we   = 1'b1;
                            bs_we   = 1'b1;
                        end
                        K_PUSH_BYTE: begin
                            bs_we    = pb_take;
                            bs_waddr = f_bs_addr(r_wb, pb_off);
                            bs_wdata = pb_last ? NEWLINE_BYTE : i_data_byte;
                        end
                        K_POP: begin
                            et_re = !pp_adv && !pp_empty;
                        end
                        default: begin
                            bs_re = rb_ok;
                        end
                    endcase
                end
            end
            S_POP_CHK: begin
                et_re = !pp_empty;
            end
            S_POP_OUT: begin
                bw_we_r = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BANKS; i++) begin
                r_bk_count[i] <= '0;
                r_bk_read[i]  <= '0;
                r_bk_wcur[i]  <= '0;
                r_bk_rcur[i]  <= '0;
            end
        end else begin
            if (bw_we_w) begin
                r_bk_count[bw_addr] <= bw_count;
                r_bk_wcur[bw_addr]  <= bw_wcur;
            end
            if (bw_we_r) begin
                r_bk_read[bw_addr] <= bw_read;
                r_bk_rcur[bw_addr] <= bw_rcur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wb         <= '0;
            r_rb         <= '0;
            r_taken      <= '0;
            r_open_count <= '0;
            r_open_trunc <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (t_kind'(i_kind))
                            K_PUSH_START: begin
                                r_wb           <= ps_tb;
                                if (ps_ovr) begin
                                    r_rb <= f_next(ps_nwb);
                                end
                                r_open_count   <= ps_cnt;
                                r_open_start   <= ps_s0;
                                r_open_trunc   <= ps_trunc;
                                r_taken        <= '0;
                                r_strobe       <= 1'b1;
                                r_status       <= ST_PUSHED;
                                r_stored_count <= COUNT_W'(ps_cnt);
                                r_type_out     <= 1'b0;
                                r_bank_out     <= '0;
                                r_offset_out   <= '0;
                                r_data_out     <= '0;
                                r_overrun      <= ps_ovr;
                            end
                            K_PUSH_BYTE: begin
                                if (r_taken != 16'hFFFF) begin
                                    r_taken <= r_taken + 16'd1;
                                end
                            end
                            K_POP: begin
                                if (pp_adv) begin
                                    r_rb    <= f_next(r_rb);
                                    r_state <= S_POP_CHK;
                                end else if (pp_empty) begin
                                    r_strobe       <= 1'b1;
                                    r_status       <= ST_EMPTY;
                                    r_stored_count <= '0;
                                    r_type_out     <= 1'b0;
                                    r_bank_out     <= '0;
                                    r_offset_out   <= '0;
                                    r_data_out     <= '0;
                                    r_overrun      <= 1'b0;
                                end else begin
                                    r_pop_bank <= r_rb;
                                    r_pop_read <= rc_read;
                                    r_pop_rcur <= rc_rcur;
                                    r_state    <= S_POP_OUT;
                                end
                            end
                            default: begin
                                r_rd_ok <= rb_ok;
                                r_state <= S_READ;
                            end
                        endcase
                    end
                end
                S_POP_CHK: begin
                    if (pp_empty) begin
                        r_strobe       <= 1'b1;
                        r_status       <= ST_EMPTY;
                        r_stored_count <= '0;
                        r_type_out     <= 1'b0;
                        r_bank_out     <= '0;
                        r_offset_out   <= '0;
                        r_data_out     <= '0;
                        r_overrun      <= 1'b0;
                        r_state        <= S_IDLE;
                    end else begin
                        r_pop_bank <= r_rb;
                        r_pop_read <= rc_read;
                        r_pop_rcur <= rc_rcur;
                        r_state    <= S_POP_OUT;
                    end
                end
                S_POP_OUT: begin
                    r_strobe       <= 1'b1;
                    r_status       <= ST_POPPED;
                    r_stored_count <= COUNT_W'(et_cnt);
                    r_type_out     <= et_type;
                    r_bank_out     <= BANK_W'(r_pop_bank);
                    r_offset_out   <= OFFSET_W'(r_pop_rcur);
                    r_data_out     <= '0;
                    r_overrun      <= 1'b0;
                    r_state        <= S_IDLE;
                end
                S_READ: begin
                    r_strobe       <= 1'b1;
                    r_status       <= ST_READ_DATA;
                    r_stored_count <= '0;
                    r_type_out     <= 1'b0;
                    r_bank_out     <= '0;
                    r_offset_out   <= '0;
                    r_data_out     <= r_rd_ok ? bs_rdata : '0;
                    r_overrun      <= 1'b0;
                    r_state        <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    bmlq_sram #(
        .WIDTH (BYTE_W),
        .DEPTH (BS_DEPTH),
        .AW    (BS_AW)
    ) u_byte_store (
        .i_clk   (i_clk),
        .i_we    (bs_we),
        .i_waddr (bs_waddr),
        .i_wdata (bs_wdata),
        .i_re    (bs_re),
        .i_raddr (bs_raddr),
        .o_rdata (bs_rdata)
    );

    bmlq_sram #(
        .WIDTH (ET_W),
        .DEPTH (ET_DEPTH),
        .AW    (ET_AW)
    ) u_entry_table (
        .i_clk   (i_clk),
        .i_we    (et_we),
        .i_waddr (et_waddr),
        .i_wdata (et_wdata),
        .i_re    (et_re),
        .i_raddr (et_raddr),
        .o_rdata (et_rdata)
    );

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_stored_count = r_stored_count;
    assign o_type_out     = r_type_out;
    assign o_bank_out     = r_bank_out;
    assign o_offset_out   = r_offset_out;
    assign o_data_out     = r_data_out;
    assign o_overrun      = r_overrun;

`ifndef NO_ASSERTIONS
    // push_byte never produces a transaction on the result side
    a_push_byte_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == K_PUSH_BYTE) |=> !o_strobe)
        else $error("push_byte produced a result");

    // bank pointers stay inside the ring
    a_bank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_wb) < NUM_BANKS) && (32'(r_rb) < NUM_BANKS))
        else $error("bank pointer out of range");

    // final pop and read states always deliver their result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_OUT || r_state == S_READ) |=> (o_strobe && !busy))
        else $error("pop or read finished without a result");

    // entry table and byte store never see a write while a pop or read is in flight
    a_no_write_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (!bs_we && !et_we))
        else $error("memory write while busy");
`endif

endmodule

FILE: test/bmlq_checker.sv
// bmlq_checker: predicts every result of the banked message log queue and scores the dut
// outputs against it; also tracks which byte store locations hold defined data
// depends on bmlq_pkg; instantiated beside the dut by banked_message_log_queue_tb
`timescale 1ns / 100ps

module bmlq_checker import bmlq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [KIND_W-1:0]   kind,
    input  logic                msg_type,
    input  logic [LEN_W-1:0]    msg_len,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic [BANK_W-1:0]   read_bank,
    input  logic [OFFSET_W-1:0] read_offset,
    input  logic                strobe,
    input  logic [STATUS_W-1:0] status,
    input  logic [COUNT_W-1:0]  stored_count,
    input  logic                type_out,
    input  logic [BANK_W-1:0]   bank_out,
    input  logic [OFFSET_W-1:0] offset_out,
    input  logic [BYTE_W-1:0]   data_out,
    input  logic                overrun,
    output int                  err_count,
    output int                  pending,
    output int                  results_seen,
    output int                  overruns_seen,
    output int                  empties_seen,
    output logic [DEF_NUM_BANKS*DEF_BANK_BYTES-1:0] written
);

    localparam int NB = DEF_NUM_BANKS;
    localparam int BB = DEF_BANK_BYTES;
    localparam int BE = DEF_BANK_ENTRIES;

    typedef struct packed {
        t_status               status;
        logic [COUNT_W-1:0]    stored_count;
        logic                  type_out;
        logic [BANK_W-1:0]     bank;
        logic [OFFSET_W-1:0]   offset;
        logic [BYTE_W-1:0]     data;
        logic                  overrun;
    } t_log_result;

    t_log_result expected_results[$];

    // queue state, at the widths of the block
    logic [BANK_W-1:0]  wr_bank;
    logic [BANK_W-1:0]  rd_bank;
    logic [6:0]         msg_count [NB];
    logic [6:0]         msgs_read [NB];
    logic [12:0]        wr_cursor [NB];
    logic [12:0]        rd_cursor [NB];
    logic [COUNT_W-1:0] entry_len [NB*BE];
    logic               entry_class [NB*BE];
    logic [BYTE_W-1:0]  byte_image [NB*BB];
    logic [LEN_W-1:0]   bytes_taken;
    logic [COUNT_W-1:0] open_count;
    logic               open_clamped;

    initial begin
        err_count     = 0;
        results_seen  = 0;
        overruns_seen = 0;
        empties_seen  = 0;
        pending       = 0;
        written       = '0;
    end

    task report_mismatch(input string what, input int want, input int got);
        $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        err_count++;
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_log_result want;
        t_log_result got;
        logic [BANK_W-1:0]  bank;
        logic [COUNT_W-1:0] cnt;
        int slot;
        int addr;
        int b;
        if (!i_rst_n) begin
            wr_bank      = '0;
            rd_bank      = '0;
            bytes_taken  = '0;
            open_count   = '0;
            open_clamped = 1'b0;
            for (b = 0; b < NB; b++) begin
                msg_count[b] = '0;
                msgs_read[b] = '0;
                wr_cursor[b] = '0;
                rd_cursor[b] = '0;
            end
            expected_results.delete();
        end else begin
            if (strobe) begin
                got.status       = t_status'(status);
                got.stored_count = stored_count;
                got.type_out     = type_out;
                got.bank         = bank_out;
                got.offset       = offset_out;
                got.data         = data_out;
                got.overrun      = overrun;
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with none outstanding", 0, int'(got.status));
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", want.status, got.status);
                    if (got.stored_count !== want.stored_count)
                        report_mismatch("stored_count", want.stored_count, got.stored_count);
                    if (got.type_out !== want.type_out)
                        report_mismatch("type_out", want.type_out, got.type_out);
                    if (got.bank !== want.bank)
                        report_mismatch("bank_out", want.bank, got.bank);
                    if (got.offset !== want.offset)
                        report_mismatch("offset_out", want.offset, got.offset);
                    if (got.data !== want.data)
                        report_mismatch("data_out", want.data, got.data);
                    if (got.overrun !== want.overrun)
                        report_mismatch("overrun", want.overrun, got.overrun);
                    if (want.overrun)
                        overruns_seen++;
                    if (want.status == ST_EMPTY)
                        empties_seen++;
                end
            end

            if (start && !busy) begin
                want = '0;
                case (t_kind'(kind))
                    K_PUSH_START: begin
                        want.status = ST_PUSHED;
                        // open the next bank when the table is full or the message won't fit
                        if (msg_count[wr_bank] >= BE ||
                            int'(wr_cursor[wr_bank]) + int'(msg_len) + 1 > BB) begin
                            wr_bank = wr_bank + 1'b1;
                            if (rd_bank == wr_bank) begin
                                rd_bank = rd_bank + 1'b1;
                                want.overrun = 1'b1;
                            end
                            msg_count[wr_bank] = '0;
                            msgs_read[wr_bank] = '0;
                            wr_cursor[wr_bank] = '0;
                            rd_cursor[wr_bank] = '0;
                        end
                        open_clamped = (int'(msg_len) > BB - 1);
                        cnt = open_clamped ? COUNT_W'(BB - 1) : msg_len[COUNT_W-1:0];
                        slot = int'(wr_bank) * BE + int'(msg_count[wr_bank]);
                        entry_len[slot]   = cnt;
                        entry_class[slot] = msg_type;
                        msg_count[wr_bank] = msg_count[wr_bank] + 1'b1;
                        // slack byte after the message reads back as zero
                        addr = int'(wr_bank) * BB + int'(wr_cursor[wr_bank]) + int'(cnt);
                        byte_image[addr] = '0;
                        written[addr] <= 1'b1;
                        wr_cursor[wr_bank] = wr_cursor[wr_bank] + cnt + 1'b1;
                        open_count  = cnt;
                        bytes_taken = '0;
                        want.stored_count = cnt;
                        expected_results.push_back(want);
                    end
                    K_PUSH_BYTE: begin
                        if (bytes_taken < open_count) begin
                            addr = int'(wr_bank) * BB + int'(wr_cursor[wr_bank])
                                 - int'(open_count) - 1 + int'(bytes_taken);
                            if (open_clamped && bytes_taken == open_count - 1'b1)
                                byte_image[addr] = NEWLINE_BYTE;
                            else
                                byte_image[addr] = data_byte;
                            written[addr] <= 1'b1;
                        end
                        if (bytes_taken != '1)
                            bytes_taken = bytes_taken + 1'b1;
                    end
                    K_POP: begin
                        bank = rd_bank;
                        if (bank != wr_bank &&
                            (msgs_read[bank] >= BE || msgs_read[bank] == msg_count[bank])) begin
                            bank = bank + 1'b1;
                            rd_bank = bank;
                        end
                        if (msgs_read[bank] >= msg_count[bank] || msgs_read[bank] >= BE) begin
                            want.status = ST_EMPTY;
                        end else begin
                            slot = int'(bank) * BE + int'(msgs_read[bank]);
                            want.status       = ST_POPPED;
                            want.stored_count = entry_len[slot];
                            want.type_out     = entry_class[slot];
                            want.bank         = bank;
                            want.offset       = rd_cursor[bank][OFFSET_W-1:0];
                            msgs_read[bank] = msgs_read[bank] + 1'b1;
                            rd_cursor[bank] = rd_cursor[bank] + entry_len[slot] + 1'b1;
                        end
                        expected_results.push_back(want);
                    end
                    default: begin
                        // bank and offset ports cannot address outside the store
                        want.status = ST_READ_DATA;
                        want.data = byte_image[int'(read_bank) * BB + int'(read_offset)];
                        expected_results.push_back(want);
                    end
                endcase
            end
        end
        pending <= expected_results.size();
    end

endmodule

FILE: test/banked_message_log_queue_tb.sv
// banked_message_log_queue_tb: directed and random command stimulus for the message log
// queue; results are predicted and checked by bmlq_checker, which runs beside the dut
// depends on bmlq_pkg, banked_message_log_queue and bmlq_checker
`timescale 1ns / 100ps

module banked_message_log_queue_tb;
    import bmlq_pkg::*;

    localparam int NB           = DEF_NUM_BANKS;
    localparam int BB           = DEF_BANK_BYTES;
    localparam int RANDOM_ITEMS = 840;
    localparam int LONG_BYTES   = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                start         = 1'b0;
    logic [KIND_W-1:0]   i_kind        = K_POP;
    logic                i_msg_type    = 1'b0;
    logic [LEN_W-1:0]    i_msg_len     = '0;
    logic [BYTE_W-1:0]   i_data_byte   = '0;
    logic [BANK_W-1:0]   i_read_bank   = '0;
    logic [OFFSET_W-1:0] i_read_offset = '0;

    logic                busy;
    logic                o_strobe;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_stored_count;
    logic                o_type_out;
    logic [BANK_W-1:0]   o_bank_out;
    logic [OFFSET_W-1:0] o_offset_out;
    logic [BYTE_W-1:0]   o_data_out;
    logic                o_overrun;

    int err_count;
    int pending;
    int results_seen;
    int overruns_seen;
    int empties_seen;
    logic [NB*BB-1:0] written;

    int items_sent  = 0;
    int idle_pct    = 0;
    int quiet_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    banked_message_log_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_msg_type     (i_msg_type),
        .i_msg_len      (i_msg_len),
        .i_data_byte    (i_data_byte),
        .i_read_bank    (i_read_bank),
        .i_read_offset  (i_read_offset),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_stored_count (o_stored_count),
        .o_type_out     (o_type_out),
        .o_bank_out     (o_bank_out),
        .o_offset_out   (o_offset_out),
        .o_data_out     (o_data_out),
        .o_overrun      (o_overrun)
    );

    bmlq_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (i_kind),
        .msg_type      (i_msg_type),
        .msg_len       (i_msg_len),
        .data_byte     (i_data_byte),
        .read_bank     (i_read_bank),
        .read_offset   (i_read_offset),
        .strobe        (o_strobe),
        .status        (o_status),
        .stored_count  (o_stored_count),
        .type_out      (o_type_out),
        .bank_out      (o_bank_out),
        .offset_out    (o_offset_out),
        .data_out      (o_data_out),
        .overrun       (o_overrun),
        .err_count     (err_count),
        .pending       (pending),
        .results_seen  (results_seen),
        .overruns_seen (overruns_seen),
        .empties_seen  (empties_seen),
        .written       (written)
    );

    // watchdog: any accepted transaction or result strobe restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t ns: watchdog, no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("banked_message_log_queue_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input t_kind k, input logic cls, input logic [LEN_W-1:0] len,
                             input logic [BYTE_W-1:0] b, input logic [BANK_W-1:0] bank,
                             input logic [OFFSET_W-1:0] off);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_kind        <= k;
        i_msg_type    <= cls;
        i_msg_len     <= len;
        i_data_byte   <= b;
        i_read_bank   <= bank;
        i_read_offset <= off;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_pop();
        send_item(K_POP, 1'($urandom), LEN_W'($urandom), BYTE_W'($urandom),
                  BANK_W'($urandom), OFFSET_W'($urandom));
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        send_item(K_PUSH_BYTE, 1'($urandom), LEN_W'($urandom), b, BANK_W'($urandom),
                  OFFSET_W'($urandom));
    endtask

    task automatic send_read(input int bank, input int off);
        send_item(K_READ_BYTE, 1'($urandom), LEN_W'($urandom), BYTE_W'($urandom),
                  BANK_W'(bank), OFFSET_W'(off));
    endtask

    // read some location that holds defined data; pop instead while nothing is stored
    task automatic read_stored_byte();
        int first;
        int idx;
        int n;
        first = $urandom_range(NB*BB - 1);
        idx = -1;
        for (n = 0; n < NB*BB && idx < 0; n++)
            if (written[(first + n) % (NB*BB)])
                idx = (first + n) % (NB*BB);
        if (idx < 0)
            send_pop();
        else
            send_read(idx / BB, idx % BB);
    endtask

    task automatic push_message(input logic cls, input logic [LEN_W-1:0] len, input int nbytes);
        int n;
        send_item(K_PUSH_START, cls, len, BYTE_W'($urandom), BANK_W'($urandom),
                  OFFSET_W'($urandom));
        for (n = 0; n < nbytes; n++) begin
            // occasional pop or read in the middle of a message
            if ($urandom_range(99) < 10) begin
                if ($urandom_range(1))
                    send_pop();
                else
                    read_stored_byte();
            end
            send_byte(BYTE_W'($urandom));
        end
    endtask

    task automatic wait_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        int phase_idle [4];
        int n;
        int phase;
        int last_phase;
        int random_base;
        int pick;
        int len;
        int nbytes;

        phase_idle[0] = 0;
        phase_idle[1] = 60;
        phase_idle[2] = 38;
        phase_idle[3] = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // byte with no open message, then a pop of the empty queue
        send_item(K_PUSH_BYTE, 1'b1, '1, 8'hFF, 2'd3, 12'hFFF);
        send_pop();
        // short error message with one byte too many, then an empty info message
        send_item(K_PUSH_START, 1'b1, 16'd3, 8'h00, 2'd0, 12'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(8'hA5);
        send_item(K_PUSH_START, 1'b0, 16'd0, 8'h00, 2'd0, 12'd0);
        send_read(0, 0);
        send_read(0, 1);
        send_read(0, 3);
        send_pop();
        send_pop();
        send_pop();
        // fill the entry table of bank 0 so that the next bank opens
        for (n = 0; n < 64; n++)
            send_item(K_PUSH_START, 1'($urandom), 16'd0, BYTE_W'($urandom),
                      BANK_W'($urandom), OFFSET_W'($urandom));
        // longest message: clamped to the bank, only its first bytes sent
        send_item(K_PUSH_START, 1'b1, 16'hFFFF, 8'h00, 2'd0, 12'd0);
        for (n = 0; n < LONG_BYTES; n++)
            send_byte(BYTE_W'($urandom));
        send_read(2, BB - 1);
        send_read(2, 0);
        send_read(2, LONG_BYTES - 1);
        // three more bank-sized messages wrap the ring and drop the two oldest banks
        for (n = 0; n < 3; n++)
            send_item(K_PUSH_START, 1'b0, 16'd4096, BYTE_W'($urandom), BANK_W'($urandom),
                      OFFSET_W'($urandom));
        send_read(3, BB - 1);
        send_read(1, BB - 1);
        for (n = 0; n < 5; n++)
            send_pop();
        wait_results();

        random_base = items_sent;
        last_phase = 0;
        while (items_sent - random_base < RANDOM_ITEMS) begin
            phase = ((items_sent - random_base) * 4) / RANDOM_ITEMS;
            if (phase > 3)
                phase = 3;
            if (phase != last_phase) begin
                wait_results();
                last_phase = phase;
            end
            idle_pct = phase_idle[phase];
            pick = $urandom_range(99);
            if (pick < 45) begin
                n = $urandom_range(99);
                if (n < 75) begin
                    len = $urandom_range(12);
                    nbytes = ($urandom_range(99) < 85) ? len : $urandom_range(len + 3);
                end else if (n < 90) begin
                    len = $urandom_range(80, 13);
                    nbytes = ($urandom_range(99) < 85) ? len : $urandom_range(len + 3);
                end else if (n < 96) begin
                    len = $urandom_range(4200, 81);
                    nbytes = $urandom_range(8);
                end else begin
                    len = $urandom_range(16'hFFFF);
                    nbytes = $urandom_range(8);
                end
                push_message(1'($urandom), LEN_W'(len), nbytes);
            end else if (pick < 65) begin
                send_pop();
            end else if (pick < 85) begin
                read_stored_byte();
            end else begin
                send_byte(BYTE_W'($urandom));
            end
        end

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("run covered %0d transactions and %0d results checked,", items_sent,
                 results_seen);
        $display("including %0d bank overruns and %0d empty pops", overruns_seen,
                 empties_seen);
        if (err_count == 0) begin
            $display("banked_message_log_queue_tb: done, clean");
        end else begin
            $display("banked_message_log_queue_tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/bmlq_pkg.sv
src/bmlq_sram.sv
src/banked_message_log_queue.sv
test/bmlq_checker.sv
test/banked_message_log_queue_tb.sv
